/* rtl/gfba_pkg.sv */
// Shared types, constants and codes for the grouped free block allocator.
`timescale 1ns / 1ps
`default_nettype none

package gfba_pkg;

  // Fixed field widths
  localparam int BLOCK_W  = 8;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 9;

  // Default sizing of the allocator
  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_NUM_BLOCKS  = 256;

  // Block limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // Request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic               op;
    logic [BLOCK_W-1:0] block_id;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  granted_block;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RELOAD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic reload;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_reload;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/gfba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/gfba_ctrl.sv */
// Controller state machine sequencing each allocator request.
`timescale 1ns / 1ps
`default_nettype none

module gfba_ctrl import gfba_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output logic      busy,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    busy        = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_reload ? ST_RELOAD : ST_IDLE;
      end
      ST_RELOAD: begin
        cmd.reload = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/gfba_dp.sv */
// Datapath: free stack, pointer, count, block limit and link store.
`timescale 1ns / 1ps
`default_nettype none

module gfba_dp import gfba_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire req_t               in_req,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  output logic                    out_valid,
  output rsp_t                    out_rsp
);

  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int LW = STACK_DEPTH * BLOCK_W;

  logic [BLOCK_W-1:0] stack_r   [STACK_DEPTH];
  logic [BLOCK_W-1:0] stack_nxt [STACK_DEPTH];
  logic [PW-1:0]      sp_r, sp_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [LIMIT_W-1:0] limit_r;
  req_t               req_r;
  rsp_t               rsp_r, rsp_nxt;
  logic               valid_r, valid_nxt;

  logic [PW-1:0]      sp_dec;
  logic [IW-1:0]      top_idx;
  logic [BLOCK_W-1:0] got;
  logic               empty, full, out_range, count_sat;
  logic [LW-1:0]      stack_flat;
  logic [LW-1:0]      link_rdata;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;

  // Decode the held stack state
  assign sp_dec    = sp_r - 1'b1;
  assign top_idx   = sp_dec[IW-1:0];
  assign got       = stack_r[top_idx];
  assign empty     = (count_r == '0) || (sp_r == '0);
  assign full      = (sp_r >= PW'(STACK_DEPTH));
  assign count_sat = (count_r == CW'(NUM_BLOCKS));
  assign out_range = ({1'b0, req_r.block_id} >= limit_r)
                  || (32'(req_r.block_id) >= NUM_BLOCKS);

  assign sts.need_reload = (req_r.op == OP_ALLOC) && !empty
                        && (sp_r == PW'(1)) && (count_r > CW'(1));

  // Flatten the stack for saving into a link group
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_flat[i*BLOCK_W +: BLOCK_W] = stack_r[i];
    end
  end

  assign ram_waddr = AW'(req_r.block_id);
  assign ram_raddr = AW'(got);

  // Next values of stack, pointer, count and result
  always_comb begin
    stack_nxt = stack_r;
    sp_nxt    = sp_r;
    count_nxt = count_r;
    rsp_nxt   = rsp_r;
    valid_nxt = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    if (cmd.exec) begin
      if (req_r.op == OP_FREE) begin
        valid_nxt = 1'b1;
        if (out_range) begin
          rsp_nxt = '{granted_block: '0, status: STATUS_RANGE};
        end else begin
          if (full) begin
            // Save the full stack into the freed block's link group
            ram_we       = 1'b1;
            stack_nxt[0] = req_r.block_id;
            sp_nxt       = PW'(1);
          end else begin
            stack_nxt[sp_r[IW-1:0]] = req_r.block_id;
            sp_nxt                  = sp_r + 1'b1;
          end
          if (!count_sat) begin
            count_nxt = count_r + 1'b1;
          end
          rsp_nxt = '{granted_block: req_r.block_id, status: STATUS_OK};
        end
      end else begin
        if (empty) begin
          valid_nxt = 1'b1;
          rsp_nxt   = '{granted_block: '0, status: STATUS_EMPTY};
        end else if (sts.need_reload) begin
          // Fetch the link group headed by the last block
          ram_re = 1'b1;
        end else begin
          valid_nxt = 1'b1;
          sp_nxt    = sp_dec;
          count_nxt = count_r - 1'b1;
          rsp_nxt   = '{granted_block: got, status: STATUS_OK};
        end
      end
    end else if (cmd.reload) begin
      // Refill the stack from the fetched link group
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack_nxt[i] = link_rdata[i*BLOCK_W +: BLOCK_W];
      end
      sp_nxt    = PW'(STACK_DEPTH);
      count_nxt = count_r - 1'b1;
      valid_nxt = 1'b1;
      rsp_nxt   = '{granted_block: got, status: STATUS_OK};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      count_r <= '0;
      limit_r <= LIMIT_RESET;
      valid_r <= 1'b0;
    end else begin
      sp_r    <= sp_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
    rsp_r   <= rsp_nxt;
    if (cmd.capture) begin
      req_r <= in_req;
    end
  end

  gfba_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (stack_flat),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (link_rdata)
  );

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

`default_nettype wire

/* rtl/grouped_free_block_allocator.sv */
// Top level of the grouped free block allocator.
//
// Usage: raise start with a request on in_req (op: allocate or free,
// block_id: block to free). The request is taken at a clock edge where
// start is high and busy is low; busy then stays high until the request
// is finished. Each request gives exactly one result on out_rsp, shown
// for a single cycle with out_valid high; the receiver cannot stall it.
// Timing: the request is captured at its accept edge and executed in the
// next cycle, so the result is registered at the end of execution and
// shown in the cycle that follows; the next request may be accepted at
// the edge that ends that cycle, not before. An allocate that pops the
// last entry of a linked group passes through an extra RELOAD state
// for the registered read of the link store RAM that refills the stack.
// The block limit is written through cfg_we / cfg_wdata, by the user
// only while idle; the block itself does not enforce this. Reset (rst_n
// low, synchronous) empties the stack, clears the free count and sets
// the block limit to 256; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module grouped_free_block_allocator import gfba_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire req_t               in_req,
  output logic                    out_valid,
  output rsp_t                    out_rsp,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  gfba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  gfba_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the grouped free block allocator.
`timescale 1ns / 1ps

module testbench;
  import gfba_pkg::*;

  localparam int DEPTH       = DEF_STACK_DEPTH;
  localparam int NBLK        = DEF_NUM_BLOCKS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 200;

  // Allocator predictor plus queue of expected responses
  class alloc_scoreboard;
    logic [DEPTH-1:0][BLOCK_W-1:0] pile;
    logic [DEPTH-1:0][BLOCK_W-1:0] groups [NBLK];
    int                            pile_top;
    int                            free_total;
    logic [LIMIT_W-1:0]            limit;
    rsp_t                          expected_q[$];
    int mismatches, checked;
    int saves, reloads, saturated, range_frees, empty_allocs, grants;

    function new();
      pile_top     = 0;
      free_total   = 0;
      limit        = LIMIT_RESET;
      mismatches   = 0;
      checked      = 0;
      saves        = 0;
      reloads      = 0;
      saturated    = 0;
      range_frees  = 0;
      empty_allocs = 0;
      grants       = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the predicted state by one accepted request
    function void note_request(req_t r);
      rsp_t               want;
      logic [BLOCK_W-1:0] got;
      want = '0;
      if (r.op == OP_FREE) begin
        if ({1'b0, r.block_id} >= limit || int'(r.block_id) >= NBLK) begin
          want.status = STATUS_RANGE;
          range_frees++;
        end else begin
          // full stack: park it in the freed block's link group
          if (pile_top >= DEPTH) begin
            groups[r.block_id] = pile;
            pile[0]  = r.block_id;
            pile_top = 1;
            saves++;
          end else begin
            pile[pile_top] = r.block_id;
            pile_top++;
          end
          if (free_total < NBLK) free_total++;
          else saturated++;
          want.granted_block = r.block_id;
          want.status        = STATUS_OK;
        end
      end else if (free_total == 0 || pile_top == 0) begin
        want.status = STATUS_EMPTY;
        empty_allocs++;
      end else begin
        got = pile[pile_top-1];
        // last entry heads a linked group: refill from it
        if (pile_top == 1 && free_total > 1) begin
          pile     = groups[got];
          pile_top = DEPTH;
          reloads++;
        end else begin
          pile_top--;
        end
        free_total--;
        grants++;
        want.granted_block = got;
        want.status        = STATUS_OK;
      end
      expected_q.push_back(want);
    endfunction

    function void report(string what, rsp_t want, rsp_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected block %0d status %0d, got block %0d status %0d",
                 what, want.granted_block, want.status, got.granted_block, got.status);
    endfunction

    // Compare one response against the oldest expectation
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report("unexpected response", '0, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.granted_block !== want.granted_block || got.status !== want.status)
        report("response", want, got);
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  req_t               in_req    = '0;
  logic               out_valid;
  rsp_t               out_rsp;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  alloc_scoreboard    sb;
  int                 cycles        = 0;
  int                 send_idle_pct = 0;
  logic [LIMIT_W-1:0] cur_limit     = LIMIT_RESET;

  // Phase plan: block limit (-1 picks one at random), free share, sender idling
  int plan_limit [PHASES] = '{256, 256, 256, 255, 0, 1, -1, 256, 128, 256};
  int plan_free  [PHASES] = '{55, 90, 90, 50, 30, 60, 50, 20, 70, 50};
  int plan_idle  [PHASES] = '{0, 81, 0, 36, 0, 81, 36, 0, 81, 36};

  grouped_free_block_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("grouped_free_block_allocator verification failed");
      $finish;
    end
  end

  // Check every response in the cycle it is shown
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_rsp);
  end

  function automatic req_t mk_req(logic op, logic [BLOCK_W-1:0] id);
    req_t r;
    r.op       = op;
    r.block_id = id;
    return r;
  endfunction

  // Bias block numbers toward the range edges
  function automatic logic [BLOCK_W-1:0] pick_block(logic [LIMIT_W-1:0] lim);
    logic [LIMIT_W-1:0] below;
    below = (lim == 0) ? '0 : lim - 1'b1;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return below[BLOCK_W-1:0];
      3:       return lim[BLOCK_W-1:0];
      default: return BLOCK_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one request, idling first at random, and hold until accepted
  task automatic issue(input req_t r);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  // Hold off until every expected response has arrived
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
    sb.set_limit(v);
  endtask

  // Runs of frees or allocates, with some stray ops mixed in
  task automatic run_phase(input int n, input int free_pct);
    req_t r;
    int   left;
    int   run;
    logic op;
    left = n;
    while (left > 0) begin
      op  = ($urandom_range(0, 99) < free_pct) ? OP_FREE : OP_ALLOC;
      run = $urandom_range(1, 24);
      while (run > 0 && left > 0) begin
        r.op = ($urandom_range(0, 9) == 0) ? ~op : op;
        r.block_id = (r.op == OP_FREE) ? pick_block(cur_limit)
                                       : BLOCK_W'($urandom_range(0, 255));
        issue(r);
        if (left == n / 2 && $urandom_range(0, 1) == 1) drain();
        run--;
        left--;
      end
    end
  endtask

  initial begin
    int lim;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty allocate, top block, fill, group save and reload, range edges
    issue(mk_req(OP_ALLOC, '0));
    issue(mk_req(OP_FREE, 8'd255));
    issue(mk_req(OP_ALLOC, 8'd255));
    issue(mk_req(OP_ALLOC, '0));
    for (int i = 0; i < DEPTH; i++) issue(mk_req(OP_FREE, BLOCK_W'(i * 17)));
    issue(mk_req(OP_FREE, 8'd170));
    issue(mk_req(OP_ALLOC, '0));
    issue(mk_req(OP_ALLOC, '0));
    set_limit('0);
    issue(mk_req(OP_FREE, '0));
    set_limit(9'd255);
    issue(mk_req(OP_FREE, 8'd255));
    issue(mk_req(OP_FREE, 8'd254));

    // Random phases across limits, op mixes and idling
    for (int p = 0; p < PHASES; p++) begin
      lim = (plan_limit[p] < 0) ? $urandom_range(0, 256) : plan_limit[p];
      set_limit(LIMIT_W'(lim));
      send_idle_pct = plan_idle[p];
      run_phase(PHASE_ITEMS, plan_free[p]);
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) $display("%0d expected responses never arrived", sb.pending());
    $display("Checked %0d responses in %0d cycles: %0d grants, %0d group saves, %0d refills",
             sb.checked, cycles, sb.grants, sb.saves, sb.reloads);
    $display("Edge cases seen: %0d empty allocates, %0d out-of-range frees, %0d saturated frees",
             sb.empty_allocs, sb.range_frees, sb.saturated);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("grouped_free_block_allocator verification clean");
    end else begin
      $display("grouped_free_block_allocator verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gfba_pkg.sv
rtl/gfba_ram.sv
rtl/gfba_ctrl.sv
rtl/gfba_dp.sv
rtl/grouped_free_block_allocator.sv
bench/testbench.sv
